### rtl/tamx_pkg.sv
// ----------------------------------------------------------------------------
// tamx_pkg: shared types and constants of the timeline aligned audio mixer
// Buffer geometry, field widths, mode and status codes, store port types.
// ----------------------------------------------------------------------------
package tamx_pkg;

	localparam int BUF_DEPTH   = 4096;
	localparam int ADDR_W      = $clog2(BUF_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int NUM_STREAMS = 8;
	localparam int STREAM_W    = 3;
	localparam int TIME_W      = 32;
	localparam int LEN_W       = 13;
	localparam int SAMPLE_W    = 16;

	localparam logic signed [17:0] SAMPLE_PEAK  = 18'sd32767;
	localparam logic signed [17:0] SAMPLE_FLOOR = -18'sd32768;

	localparam logic [1:0] MODE_HEADER  = 2'd0;
	localparam logic [1:0] MODE_SAMPLE  = 2'd1;
	localparam logic [1:0] MODE_CONSUME = 2'd2;
	localparam logic [1:0] MODE_READ    = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DISCARD  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_TOO_OLD  = 3'd3;
	localparam logic [2:0] ST_HOLE     = 3'd4;
	localparam logic [2:0] ST_STALLED  = 3'd5;

	localparam logic [1:0] PH_WAIT_FIRST = 2'd0;
	localparam logic [1:0] PH_WAIT_LAT   = 2'd1;
	localparam logic [1:0] PH_MIX        = 2'd2;

	localparam logic [1:0] REG_SLOTS = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_START = 2'd2;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} store_wr_t;

endpackage

### rtl/tamx_store.sv
// ----------------------------------------------------------------------------
// tamx_store: mixing buffer memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tamx_store import tamx_pkg::*; (
	input  logic                clk,
	input  store_wr_t           wr,
	input  logic [ADDR_W-1:0]   rd_addr,
	output logic [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem [BUF_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### rtl/tamx_softmix.sv
// ----------------------------------------------------------------------------
// tamx_softmix: soft-clip mixing of two signed 16-bit samples
// The product is registered; the scaled correction and clamp follow.
// ----------------------------------------------------------------------------
module tamx_softmix import tamx_pkg::*; (
	input  logic                       clk,
	input  logic signed [SAMPLE_W-1:0] a,
	input  logic signed [SAMPLE_W-1:0] b,
	output logic        [SAMPLE_W-1:0] mixed
);

	logic signed [SAMPLE_W-1:0] a_s1, b_s1;
	logic signed [31:0]         p_s1;

	always_ff @(posedge clk) begin
		a_s1 <= a;
		b_s1 <= b;
		p_s1 <= a * b;
	end

	logic [29:0]        pm;
	logic [14:0]        q0;
	logic [16:0]        rem;
	logic [15:0]        qpos;
	logic signed [17:0] sum, r;

	always_comb begin
		pm   = p_s1[29:0];
		q0   = pm[29:15];
		// Division by 32767: quotient estimate by a shift, then up to two corrections.
		rem  = {2'b00, pm[14:0]} + {2'b00, q0};
		qpos = {1'b0, q0} + 16'(rem >= 17'd32767) + 16'(rem >= 17'd65534);
		sum  = 18'(a_s1) + 18'(b_s1);
		if (a_s1 < 0 && b_s1 < 0) begin
			r = sum + $signed({3'b000, q0});
		end else if (a_s1 > 0 && b_s1 > 0) begin
			r = sum - $signed({2'b00, qpos});
		end else begin
			r = sum;
		end
		if (r > SAMPLE_PEAK) begin
			r = SAMPLE_PEAK;
		end else if (r < SAMPLE_FLOOR) begin
			r = SAMPLE_FLOOR;
		end
		mixed = r[SAMPLE_W-1:0];
	end

endmodule

### rtl/timeline_aligned_audio_mixer.sv
// ----------------------------------------------------------------------------
// timeline_aligned_audio_mixer: multi-stream soft-clip mixer on one timeline
// Sequencer around a shared soft-mix unit, a buffer memory and a stream scan.
// ----------------------------------------------------------------------------
// Channel   | Handshake              | Signals
// request   | start && !busy         | mode stream packet_len hole latency_known
//           |                        | latency now_time sample last read_index
// result    | done, one cycle        | flush_request status read_data
//           |                        | pending_count pending_time finished_new
// config    | cfg_valid && cfg_ready | cfg_index cfg_data
//
// A request decided at decode goes on to the result, a read via S_READ, a
// header via S_HDR2, after S_HDR1 when its first known latency places the
// stream, a mixed sample via S_SRD and S_SMIX. Any step that finishes a
// span adds a scan of all streams and S_FEND. A consume shifts or clears one
// buffer word per cycle. Idle follows each result before the next request.
// After reset the buffer is cleared with busy high.
// Results must be taken in the done cycle; they are held to the next request.
// ----------------------------------------------------------------------------
module timeline_aligned_audio_mixer import tamx_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 mode,
	input  logic [STREAM_W-1:0]        stream,
	input  logic [LEN_W-1:0]           packet_len,
	input  logic                       hole,
	input  logic                       latency_known,
	input  logic [TIME_W-1:0]          latency,
	input  logic [TIME_W-1:0]          now_time,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	input  logic [ADDR_W-1:0]          read_index,
	output logic                       done,
	output logic                       flush_request,
	output logic [2:0]                 status,
	output logic signed [SAMPLE_W-1:0] read_data,
	output logic [CNT_W-1:0]           pending_count,
	output logic [TIME_W-1:0]          pending_time,
	output logic [CNT_W-1:0]           finished_new,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);

	typedef enum logic [12:0] {
		S_CLEAR  = 13'b0000000000001,
		S_IDLE   = 13'b0000000000010,
		S_DECODE = 13'b0000000000100,
		S_HDR1   = 13'b0000000001000,
		S_HDR2   = 13'b0000000010000,
		S_SRD    = 13'b0000000100000,
		S_SMIX   = 13'b0000001000000,
		S_READ   = 13'b0000010000000,
		S_SCAN   = 13'b0000100000000,
		S_FEND   = 13'b0001000000000,
		S_CSHIFT = 13'b0010000000000,
		S_CCLR   = 13'b0100000000000,
		S_RESP   = 13'b1000000000000
	} state_t;

	state_t state_q;

	// Configuration
	logic [12:0]       slots_q;
	logic [TIME_W-1:0] limit_q, origin_q;

	// Captured request
	logic [1:0]                 mode_q;
	logic [STREAM_W-1:0]        s_q;
	logic [LEN_W-1:0]           len_q;
	logic                       hole_q, lknown_q, last_q;
	logic [TIME_W-1:0]          lat_q, now_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [ADDR_W-1:0]          ridx_q;

	// Timeline and stream state
	logic [CNT_W-1:0]  eo_q;
	logic [TIME_W-1:0] et_q;
	logic              started_q;
	logic [1:0]        phase_q [NUM_STREAMS];
	logic [TIME_W-1:0] st_q    [NUM_STREAMS];
	logic              disc_q  [NUM_STREAMS];

	// Sequencer work registers
	logic [CNT_W-1:0]    cnt_q, sh_q, rem_q;
	logic [ADDR_W-1:0]   slot_q, cp_addr_q;
	logic                cp_valid_q;
	logic [STREAM_W-1:0] scan_q;
	logic [TIME_W-1:0]   lo_q;
	logic                any_q;

	// Result registers
	logic                flush_q;
	logic [2:0]          status_q;
	logic [SAMPLE_W-1:0] rdata_q;
	logic [CNT_W-1:0]    fin_q;

	logic [SAMPLE_W-1:0] mem_rdata, mixed;
	logic [ADDR_W-1:0]   rd_addr;
	store_wr_t           wr;

	tamx_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (mem_rdata)
	);

	tamx_softmix u_mix (
		.clk   (clk),
		.a     ($signed(mem_rdata)),
		.b     (sample_q),
		.mixed (mixed)
	);

	// Slots in use and free space
	logic [CNT_W-1:0] n_use, fr;
	always_comb begin
		if (slots_q == '0) begin
			n_use = CNT_W'(1);
		end else if (slots_q > 13'(BUF_DEPTH)) begin
			n_use = CNT_W'(BUF_DEPTH);
		end else begin
			n_use = CNT_W'(slots_q);
		end
		fr = (eo_q < n_use) ? n_use - eo_q : '0;
	end

	// Stream time under the current index
	logic [STREAM_W-1:0] sel;
	logic [TIME_W-1:0]   st_sel;
	logic [1:0]          ph_sel;
	assign sel    = (state_q == S_SCAN) ? scan_q : s_q;
	assign st_sel = st_q[sel];
	assign ph_sel = phase_q[sel];

	// Sample placement
	logic [TIME_W-1:0] dt;
	logic [CNT_W-1:0]  slot_w;
	logic              s_old, s_over;
	always_comb begin
		dt     = st_sel - et_q;
		slot_w = eo_q + dt[CNT_W-1:0];
		s_old  = st_sel < et_q;
		s_over = (dt >= TIME_W'(BUF_DEPTH)) || (slot_w >= n_use);
	end

	// Overflow check at a header
	logic [TIME_W-1:0] back, len_w;
	logic              ovf;
	always_comb begin
		len_w = TIME_W'(len_q);
		back  = et_q - st_sel;
		if (!s_old) begin
			ovf = (dt > TIME_W'(fr)) || (len_w > TIME_W'(fr) - dt);
		end else begin
			ovf = (len_w > back) && (len_w - back > TIME_W'(fr));
		end
	end

	// Scan candidate and finish span
	logic [TIME_W-1:0] cand, span;
	assign cand = (st_sel < et_q) ? et_q : st_sel;
	assign span = lo_q - et_q;

	logic [TIME_W-1:0] aligned;
	assign aligned = now_q - lat_q - origin_q;

	always_comb begin
		rd_addr = '0;
		wr      = '0;
		case (state_q)
			S_CLEAR: begin
				wr.en   = 1'b1;
				wr.addr = cnt_q[ADDR_W-1:0];
			end
			S_DECODE: begin
				rd_addr = (mode_q == MODE_READ) ? ridx_q : slot_w[ADDR_W-1:0];
			end
			S_SMIX: begin
				wr.en   = 1'b1;
				wr.addr = slot_q;
				wr.data = mixed;
			end
			S_CSHIFT: begin
				rd_addr = ADDR_W'(cnt_q + sh_q);
				wr.en   = cp_valid_q;
				wr.addr = cp_addr_q;
				wr.data = mem_rdata;
			end
			S_CCLR: begin
				wr.en   = cnt_q < n_use;
				wr.addr = cnt_q[ADDR_W-1:0];
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q  <= 13'(BUF_DEPTH);
			limit_q  <= '0;
			origin_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SLOTS: slots_q  <= cfg_data[12:0];
				REG_LIMIT: limit_q  <= cfg_data;
				REG_START: origin_q <= cfg_data;
				default:   slots_q  <= slots_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			mode_q   <= mode;
			s_q      <= stream;
			len_q    <= packet_len;
			hole_q   <= hole;
			lknown_q <= latency_known;
			lat_q    <= latency;
			now_q    <= now_time;
			sample_q <= sample;
			last_q   <= last;
			ridx_q   <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			eo_q       <= '0;
			et_q       <= '0;
			started_q  <= 1'b0;
			cnt_q      <= '0;
			sh_q       <= '0;
			rem_q      <= '0;
			slot_q     <= '0;
			cp_addr_q  <= '0;
			cp_valid_q <= 1'b0;
			scan_q     <= '0;
			lo_q       <= '0;
			any_q      <= 1'b0;
			flush_q    <= 1'b0;
			status_q   <= ST_OK;
			rdata_q    <= '0;
			fin_q      <= '0;
			for (int i = 0; i < NUM_STREAMS; i++) begin
				phase_q[i] <= PH_WAIT_FIRST;
				st_q[i]    <= '0;
				disc_q[i]  <= 1'b0;
			end
		end else begin
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(BUF_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						flush_q  <= 1'b0;
						status_q <= ST_OK;
						rdata_q  <= '0;
						fin_q    <= '0;
						state_q  <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (mode_q)
						MODE_HEADER, MODE_SAMPLE: begin
							if (int'(s_q) >= NUM_STREAMS) begin
								status_q <= ST_DISCARD;
								state_q  <= S_RESP;
							end else if (mode_q == MODE_HEADER) begin
								if (ph_sel == PH_WAIT_FIRST) begin
									flush_q     <= 1'b1;
									phase_q[s_q] <= PH_WAIT_LAT;
									disc_q[s_q] <= 1'b1;
									status_q    <= ST_DISCARD;
									state_q     <= S_RESP;
								end else if (ph_sel == PH_WAIT_LAT && !lknown_q) begin
									disc_q[s_q] <= 1'b1;
									status_q    <= ST_DISCARD;
									state_q     <= S_RESP;
								end else if (ph_sel == PH_WAIT_LAT) begin
									disc_q[s_q] <= 1'b0;
									state_q     <= S_HDR1;
								end else begin
									disc_q[s_q] <= 1'b0;
									state_q     <= S_HDR2;
								end
							end else begin
								if (disc_q[s_q] || ph_sel < PH_MIX) begin
									status_q <= ST_DISCARD;
									if (last_q) begin
										disc_q[s_q] <= 1'b0;
									end
									state_q <= S_RESP;
								end else begin
									st_q[s_q] <= st_sel + 1'b1;
									if (s_old || s_over) begin
										status_q <= s_old ? ST_TOO_OLD : ST_OVERFLOW;
										state_q  <= last_q ? S_SCAN : S_RESP;
									end else begin
										slot_q  <= slot_w[ADDR_W-1:0];
										state_q <= S_SRD;
									end
									scan_q <= '0;
									any_q  <= 1'b0;
								end
							end
						end
						MODE_CONSUME: begin
							sh_q    <= (eo_q < n_use) ? eo_q : n_use;
							rem_q   <= n_use - ((eo_q < n_use) ? eo_q : n_use);
							cnt_q   <= '0;
							eo_q    <= '0;
							state_q <= S_CSHIFT;
						end
						default: begin
							state_q <= S_READ;
						end
					endcase
				end
				S_HDR1: begin
					// First known latency places the stream and may start the timeline.
					if (lat_q > limit_q) begin
						st_q[s_q] <= started_q ? et_q : aligned;
					end else begin
						st_q[s_q] <= aligned;
					end
					if (!started_q) begin
						et_q      <= aligned;
						started_q <= 1'b1;
					end
					phase_q[s_q] <= PH_MIX;
					state_q      <= S_HDR2;
				end
				S_HDR2: begin
					scan_q <= '0;
					any_q  <= 1'b0;
					if (hole_q || len_q == '0) begin
						st_q[s_q] <= st_sel + len_w;
						status_q  <= hole_q ? ST_HOLE : ST_OK;
						state_q   <= S_SCAN;
					end else if (ovf) begin
						st_q[s_q]   <= st_sel + len_w;
						disc_q[s_q] <= 1'b1;
						status_q    <= ST_OVERFLOW;
						state_q     <= S_SCAN;
					end else begin
						if (s_old && back >= len_w) begin
							status_q <= ST_TOO_OLD;
						end
						state_q <= S_RESP;
					end
				end
				S_SRD: begin
					state_q <= S_SMIX;
				end
				S_SMIX: begin
					state_q <= last_q ? S_SCAN : S_RESP;
				end
				S_READ: begin
					rdata_q <= mem_rdata;
					state_q <= S_RESP;
				end
				S_SCAN: begin
					if (ph_sel >= PH_MIX) begin
						if (!any_q || cand < lo_q) begin
							lo_q <= cand;
						end
						any_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == STREAM_W'(NUM_STREAMS - 1)) begin
						state_q <= S_FEND;
					end
				end
				S_FEND: begin
					if (any_q) begin
						if (span > TIME_W'(fr)) begin
							status_q <= ST_STALLED;
						end else begin
							eo_q  <= eo_q + span[CNT_W-1:0];
							et_q  <= et_q + span;
							fin_q <= span[CNT_W-1:0];
						end
					end
					state_q <= S_RESP;
				end
				S_CSHIFT: begin
					cp_addr_q  <= cnt_q[ADDR_W-1:0];
					cp_valid_q <= cnt_q < rem_q;
					if (cnt_q < rem_q) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_CCLR;
					end
				end
				S_CCLR: begin
					cp_valid_q <= 1'b0;
					if (cnt_q < n_use) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = state_q != S_IDLE;
	assign done          = state_q == S_RESP;
	assign flush_request = flush_q;
	assign status        = status_q;
	assign read_data     = $signed(rdata_q);
	assign pending_count = eo_q;
	assign pending_time  = et_q - TIME_W'(eo_q);
	assign finished_new  = fin_q;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the timeline aligned audio mixer
// Drives headers, samples, consumes and slot reads through the command port,
// predicts every result with an in-bench mixer model and compares each field.
// ----------------------------------------------------------------------------
module tb;
	import tamx_pkg::*;

	localparam int LIMIT_CYCLES = 8000000;

	typedef struct {
		logic [1:0]  mode;
		logic [2:0]  stream;
		logic [12:0] len;
		logic        hole;
		logic        lknown;
		logic [31:0] lat;
		logic [31:0] now;
		logic [15:0] smp;
		logic        last;
		logic [11:0] ridx;
	} request_t;

	typedef struct {
		logic        flush;
		logic [2:0]  status;
		logic [15:0] rdata;
		logic [12:0] pcount;
		logic [31:0] ptime;
		logic [12:0] fin;
	} mix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] mode = MODE_READ;
	logic [STREAM_W-1:0] stream = '0;
	logic [LEN_W-1:0] packet_len = '0;
	logic hole = 1'b0;
	logic latency_known = 1'b0;
	logic [TIME_W-1:0] latency = '0;
	logic [TIME_W-1:0] now_time = '0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic last = 1'b0;
	logic [ADDR_W-1:0] read_index = '0;
	logic done;
	logic flush_request;
	logic [2:0] status;
	logic signed [SAMPLE_W-1:0] read_data;
	logic [CNT_W-1:0] pending_count;
	logic [TIME_W-1:0] pending_time;
	logic [CNT_W-1:0] finished_new;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_SLOTS;
	logic [31:0] cfg_data = '0;

	timeline_aligned_audio_mixer u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.stream(stream), .packet_len(packet_len), .hole(hole),
		.latency_known(latency_known), .latency(latency), .now_time(now_time),
		.sample(sample), .last(last), .read_index(read_index), .done(done),
		.flush_request(flush_request), .status(status), .read_data(read_data),
		.pending_count(pending_count), .pending_time(pending_time),
		.finished_new(finished_new), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mirror of the mixer state.
	logic [15:0] mix_mem [BUF_DEPTH];
	int unsigned edge_off;
	logic [31:0] edge_t;
	bit timeline_on;
	logic [1:0] phase_of [NUM_STREAMS];
	logic [31:0] time_of [NUM_STREAMS];
	bit drop_of [NUM_STREAMS];
	logic [12:0] slots_reg;
	logic [31:0] limit_reg;
	logic [31:0] origin_reg;
	logic [2:0] step_status;

	mix_result_t expected_q[$];
	int mismatches = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;
	logic [31:0] wall_clock = 32'd1000;

	function automatic int unsigned slots_used();
		if (slots_reg == 0)
			return 1;
		if (slots_reg > BUF_DEPTH)
			return BUF_DEPTH;
		return 32'(slots_reg);
	endfunction

	function automatic longint unsigned room_left();
		int unsigned s;
		s = slots_used();
		return edge_off < s ? 64'(s - edge_off) : 64'd0;
	endfunction

	function automatic logic [15:0] soft_clip_mix(logic [15:0] x, logic [15:0] y);
		int a;
		int b;
		int r;
		a = 32'($signed(x));
		b = 32'($signed(y));
		if (a < 0 && b < 0)
			r = (a + b) - (a * b) / -32768;
		else if (a > 0 && b > 0)
			r = (a + b) - (a * b) / 32767;
		else
			r = a + b;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// Advances the edge over the span that every mixing stream has passed.
	function automatic logic [12:0] advance_edge();
		logic [31:0] lo;
		logic [31:0] t;
		longint unsigned span;
		bit any;
		any = 1'b0;
		lo = '0;
		for (int i = 0; i < NUM_STREAMS; i++) begin
			if (phase_of[i] == PH_MIX) begin
				t = time_of[i] < edge_t ? edge_t : time_of[i];
				if (!any || t < lo)
					lo = t;
				any = 1'b1;
			end
		end
		if (!any)
			return '0;
		span = 64'(lo - edge_t);
		if (span > room_left()) begin
			step_status = ST_STALLED;
			return '0;
		end
		edge_off += 32'(span);
		edge_t = edge_t + span[31:0];
		return span[12:0];
	endfunction

	function automatic bit overflows(logic [31:0] st, longint unsigned len);
		longint unsigned fr;
		longint unsigned d;
		fr = room_left();
		if (st >= edge_t) begin
			d = 64'(st - edge_t);
			return d > fr || len > fr - d;
		end
		d = 64'(edge_t - st);
		return len > d && len - d > fr;
	endfunction

	function automatic mix_result_t predict_mix(request_t r);
		mix_result_t o;
		int unsigned s;
		int unsigned n;
		int unsigned sh;
		longint unsigned d;
		logic [31:0] t;
		o = '{default: '0};
		step_status = ST_OK;
		s = 32'(r.stream);
		if (r.mode == MODE_HEADER) begin
			drop_of[s] = 1'b0;
			if (phase_of[s] == PH_WAIT_FIRST) begin
				o.flush = 1'b1;
				phase_of[s] = PH_WAIT_LAT;
				drop_of[s] = 1'b1;
				step_status = ST_DISCARD;
			end else if (phase_of[s] == PH_WAIT_LAT && !r.lknown) begin
				drop_of[s] = 1'b1;
				step_status = ST_DISCARD;
			end else begin
				if (phase_of[s] == PH_WAIT_LAT) begin
					time_of[s] = r.now - r.lat - origin_reg;
					if (!timeline_on) begin
						edge_t = time_of[s];
						timeline_on = 1'b1;
					end
					if (r.lat > limit_reg)
						time_of[s] = edge_t;
					phase_of[s] = PH_MIX;
				end
				if (r.hole || r.len == 0) begin
					time_of[s] = time_of[s] + 32'(r.len);
					step_status = r.hole ? ST_HOLE : ST_OK;
					o.fin = advance_edge();
				end else if (overflows(time_of[s], 64'(r.len))) begin
					time_of[s] = time_of[s] + 32'(r.len);
					drop_of[s] = 1'b1;
					step_status = ST_OVERFLOW;
					o.fin = advance_edge();
				end else if (time_of[s] < edge_t && edge_t - time_of[s] >= 32'(r.len)) begin
					step_status = ST_TOO_OLD;
				end
			end
		end else if (r.mode == MODE_SAMPLE) begin
			if (drop_of[s] || phase_of[s] != PH_MIX) begin
				step_status = ST_DISCARD;
				if (r.last)
					drop_of[s] = 1'b0;
			end else begin
				t = time_of[s];
				if (t < edge_t) begin
					step_status = ST_TOO_OLD;
				end else begin
					d = 64'(t - edge_t);
					if (d >= BUF_DEPTH || edge_off + d >= slots_used())
						step_status = ST_OVERFLOW;
					else
						mix_mem[edge_off + d] = soft_clip_mix(mix_mem[edge_off + d], r.smp);
				end
				time_of[s] = t + 32'd1;
				if (r.last)
					o.fin = advance_edge();
			end
		end else if (r.mode == MODE_CONSUME) begin
			n = slots_used();
			sh = edge_off < n ? edge_off : n;
			for (int i = 0; i < n - sh; i++)
				mix_mem[i] = mix_mem[i + sh];
			for (int i = n - sh; i < n; i++)
				mix_mem[i] = '0;
			edge_off = 0;
		end else begin
			o.rdata = mix_mem[r.ridx];
		end
		o.status = step_status;
		o.pcount = edge_off[12:0];
		o.ptime = edge_t - edge_off;
		return o;
	endfunction

	// Results are checked against the oldest prediction.
	always @(posedge clk) begin
		mix_result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing expected, status %0d", status);
			end else begin
				e = expected_q.pop_front();
				if (flush_request !== e.flush || status !== e.status ||
						read_data !== e.rdata || pending_count !== e.pcount ||
						pending_time !== e.ptime || finished_new !== e.fin) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: exp f%0d s%0d r%0h c%0d t%0h n%0d",
							" got f%0d s%0d r%0h c%0d t%0h n%0d"},
							e.flush, e.status, e.rdata, e.pcount, e.ptime, e.fin,
							flush_request, status, read_data, pending_count,
							pending_time, finished_new);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(request_t r);
		int gap;
		if (!no_idle && $urandom_range(99) < 28) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		mode <= r.mode;
		stream <= r.stream;
		packet_len <= r.len;
		hole <= r.hole;
		latency_known <= r.lknown;
		latency <= r.lat;
		now_time <= r.now;
		sample <= r.smp;
		last <= r.last;
		read_index <= r.ridx;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_q.push_back(predict_mix(r));
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SLOTS)
			slots_reg = val[12:0];
		else if (idx == REG_LIMIT)
			limit_reg = val;
		else if (idx == REG_START)
			origin_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic request_t make_req(logic [1:0] m, logic [2:0] s);
		request_t r;
		r = '{default: '0};
		r.mode = m;
		r.stream = s;
		return r;
	endfunction

	task automatic send_header(logic [2:0] s, logic [12:0] len, logic h, logic k,
			logic [31:0] lat, logic [31:0] now);
		request_t r;
		r = make_req(MODE_HEADER, s);
		r.len = len;
		r.hole = h;
		r.lknown = k;
		r.lat = lat;
		r.now = now;
		send_request(r);
	endtask

	task automatic send_sample(logic [2:0] s, logic [15:0] v, logic l);
		request_t r;
		r = make_req(MODE_SAMPLE, s);
		r.smp = v;
		r.last = l;
		send_request(r);
	endtask

	task automatic send_read(logic [11:0] idx);
		request_t r;
		r = make_req(MODE_READ, 3'd0);
		r.ridx = idx;
		send_request(r);
	endtask

	task automatic test_directed();
		send_header(3'd0, 13'd3, 1'b0, 1'b1, 32'd5, 32'd100);
		send_header(3'd0, 13'd3, 1'b0, 1'b0, 32'd5, 32'd100);
		send_sample(3'd0, 16'h1234, 1'b1);
		send_header(3'd0, 13'd3, 1'b0, 1'b1, 32'd5, 32'd100);
		send_sample(3'd0, 16'h7fff, 1'b0);
		send_sample(3'd0, 16'h8000, 1'b0);
		send_sample(3'd0, 16'hffff, 1'b1);
		send_header(3'd1, 13'd2, 1'b0, 1'b1, 32'd0, 32'd0);
		send_header(3'd1, 13'd2, 1'b0, 1'b1, 32'hffffffff, 32'hffffffff);
		send_sample(3'd1, 16'h7fff, 1'b0);
		send_sample(3'd1, 16'h8000, 1'b1);
		send_header(3'd0, 13'd4, 1'b1, 1'b1, 32'd0, 32'd0);
		send_header(3'd1, 13'd0, 1'b0, 1'b1, 32'd0, 32'd0);
		send_header(3'd1, 13'd4096, 1'b0, 1'b1, 32'd0, 32'd0);
		send_sample(3'd1, 16'h0001, 1'b1);
		send_read(12'd0);
		send_read(12'd1);
		send_read(12'd4095);
		send_request(make_req(MODE_CONSUME, 3'd0));
		send_read(12'd0);
		wait_idle();
	endtask

	task automatic test_too_old();
		write_reg(REG_LIMIT, 32'hffffffff);
		send_header(3'd7, 13'd2, 1'b0, 1'b0, 32'd0, 32'd0);
		// Placed well before the edge, so the whole packet is skipped.
		send_header(3'd7, 13'd2, 1'b0, 1'b1, 32'd60, 32'd100);
		send_sample(3'd7, 16'h0100, 1'b0);
		send_sample(3'd7, 16'h0200, 1'b1);
		send_read(12'd2);
		wait_idle();
	endtask

	task automatic random_item();
		int pick;
		int len;
		int sent;
		logic [2:0] s;
		request_t r;
		pick = $urandom_range(99);
		if (pick < 70) begin
			s = 3'($urandom_range(7));
			len = $urandom_range(99) < 3 ? $urandom_range(13, 4096) : $urandom_range(1, 12);
			send_header(s, len[12:0], $urandom_range(99) < 5, $urandom_range(99) < 85,
				$urandom_range(60), wall_clock + $urandom_range(60));
			wall_clock += len;
			sent = len > 12 ? 12 : len;
			for (int i = 0; i < sent; i++)
				send_sample(s, 16'($urandom), i == sent - 1);
		end else if (pick < 80) begin
			send_request(make_req(MODE_CONSUME, 3'($urandom_range(7))));
		end else if (pick < 90) begin
			send_read(12'($urandom_range(4095)));
		end else begin
			r.mode = $urandom_range(1) ? MODE_SAMPLE : MODE_HEADER;
			r.stream = 3'($urandom);
			r.len = 13'($urandom_range(4096));
			r.hole = 1'($urandom);
			r.lknown = 1'($urandom);
			r.lat = $urandom;
			r.now = $urandom;
			r.smp = 16'($urandom);
			r.last = 1'($urandom);
			r.ridx = 12'($urandom);
			send_request(r);
		end
	endtask

	task automatic test_random_phase(logic [12:0] slots, logic [31:0] lim,
			logic [31:0] org, int items, bit calm);
		write_reg(REG_SLOTS, {19'd0, slots});
		write_reg(REG_LIMIT, lim);
		write_reg(REG_START, org);
		no_idle = calm;
		for (int k = 0; k < items; k++)
			random_item();
		no_idle = 1'b0;
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < BUF_DEPTH; i++)
			mix_mem[i] = '0;
		for (int i = 0; i < NUM_STREAMS; i++) begin
			phase_of[i] = PH_WAIT_FIRST;
			time_of[i] = '0;
			drop_of[i] = 1'b0;
		end
		edge_off = 0;
		edge_t = '0;
		timeline_on = 1'b0;
		slots_reg = 13'd4096;
		limit_reg = '0;
		origin_reg = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_too_old();
		test_random_phase(13'd64, 32'd0, 32'd0, 60, 1'b0);
		test_random_phase(13'd0, 32'd30, 32'hffffffff, 40, 1'b0);
		test_random_phase(13'd37, $urandom, $urandom, 60, 1'b1);
		test_random_phase(13'd8191, 32'hffffffff, 32'd0, 25, 1'b0);
		test_random_phase(13'd200, 32'd0, 32'd12345, 60, 1'b0);
		test_random_phase(13'd1, 32'd0, 32'd0, 20, 1'b0);
		@(negedge clk);
		start <= 1'b0;
		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
